// ----- rtl/core/ugnb_pkg.sv -----
`default_nettype none
package ugnb_pkg;

  localparam int MAX_GRID_LENGTH = 32;
  localparam int SLOTS_PER_CELL  = 4;
  localparam int MAX_PARTICLES   = 4096;

  localparam int COORD_W   = 6;
  localparam int PID_W     = 12;
  localparam int SLOT_W    = 13;
  localparam int NUM_W     = 5;
  localparam int CNT_W     = 3;
  localparam int ROW_W     = SLOTS_PER_CELL * PID_W;
  localparam int LAST_NBR  = 26;

  localparam logic [SLOT_W-1:0] EMPTY_SLOT = '1;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_INSERT,
    OP_REJECT,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [PID_W-1:0]   pid;
  } cmd_t;

  typedef struct packed {
    logic [SLOTS_PER_CELL-1:0][SLOT_W-1:0] slots;
    logic [NUM_W-1:0]                      number;
    logic                                  overflowed;
    logic                                  accepted;
  } res_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_REJ,
    S_CLEAR,
    S_CLR_DONE,
    S_Q_FIRST,
    S_QUERY
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/ugnb_ram.sv -----
`default_nettype none
module ugnb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/ugnb_front.sv -----
`default_nettype none
module ugnb_front #(
  parameter int MAX_GRID_LENGTH = ugnb_pkg::MAX_GRID_LENGTH
) (
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [6:0]  cell_x,
  input  wire logic [6:0]  cell_y,
  input  wire logic [6:0]  cell_z,
  input  wire logic [11:0] particle_id,
  input  wire logic [5:0]  grid_length,
  input  wire logic        q_full,
  output logic             q_push,
  output ugnb_pkg::cmd_t   q_cmd
);

  logic [6:0] len;
  logic [6:0] hi;
  logic       outside;
  logic       pid_bad;

  function automatic logic [5:0] clamp_in(input logic [6:0] v, input logic [6:0] h);
    logic [5:0] r;
    if (v[6] || v == 7'd0) begin
      r = 6'd1;
    end else if (v > h) begin
      r = h[5:0];
    end else begin
      r = v[5:0];
    end
    return r;
  endfunction

  always_comb begin
    if (grid_length < 6'd3) begin
      len = 7'd3;
    end else if ({1'b0, grid_length} > 7'(MAX_GRID_LENGTH)) begin
      len = 7'(MAX_GRID_LENGTH);
    end else begin
      len = {1'b0, grid_length};
    end
    hi = len - 7'd2;
    outside = cell_x[6] || cell_y[6] || cell_z[6] ||
              cell_x >= len || cell_y >= len || cell_z >= len;
    pid_bad = {1'b0, particle_id} >= 13'(ugnb_pkg::MAX_PARTICLES);

    q_cmd.pid = particle_id;
    q_cmd.x   = cell_x[5:0];
    q_cmd.y   = cell_y[5:0];
    q_cmd.z   = cell_z[5:0];
    q_cmd.op  = ugnb_pkg::OP_CLEAR;
    case (kind)
      ugnb_pkg::KIND_CLEAR: q_cmd.op = ugnb_pkg::OP_CLEAR;
      ugnb_pkg::KIND_INSERT: begin
        q_cmd.op = (outside || pid_bad) ? ugnb_pkg::OP_REJECT : ugnb_pkg::OP_INSERT;
      end
      ugnb_pkg::KIND_QUERY: begin
        q_cmd.op = ugnb_pkg::OP_QUERY;
        q_cmd.x  = clamp_in(cell_x, hi);
        q_cmd.y  = clamp_in(cell_y, hi);
        q_cmd.z  = clamp_in(cell_z, hi);
      end
      default: q_cmd.op = ugnb_pkg::OP_CLEAR;
    endcase
  end

  // unused kind is taken and dropped
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && kind <= ugnb_pkg::KIND_QUERY;

endmodule
`default_nettype wire

// ----- rtl/core/ugnb_cmd_queue.sv -----
`default_nettype none
module ugnb_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ugnb_pkg::cmd_t push_cmd,
  output logic                full,
  output logic                pop_valid,
  input  wire logic           pop,
  output ugnb_pkg::cmd_t      pop_cmd
);

  ugnb_pkg::cmd_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  assign full      = fill == 2'd2;
  assign pop_valid = fill != 2'd0;
  assign pop_cmd   = entry[rd_ptr];

endmodule
`default_nettype wire

// ----- rtl/core/ugnb_back.sv -----
`default_nettype none
module ugnb_back #(
  parameter int MAX_GRID_LENGTH = ugnb_pkg::MAX_GRID_LENGTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire ugnb_pkg::cmd_t q_cmd,
  output logic                q_pop,
  output logic                res_valid,
  input  wire logic           res_ready,
  output ugnb_pkg::res_t      res,
  output logic                res_last
);

  localparam int CB    = $clog2(MAX_GRID_LENGTH);
  localparam int AW    = 3 * CB;
  localparam int DEPTH = 1 << AW;

  ugnb_pkg::state_t state, state_next;
  ugnb_pkg::cmd_t   cmd;
  logic [AW-1:0]    walk;
  logic [1:0]       dx, dy, dz;
  logic [1:0]       dx_next, dy_next, dz_next;
  logic [4:0]       nbr;
  logic             out_free;
  logic             emit;
  ugnb_pkg::res_t   res_next;
  logic             last_next;

  logic [AW-1:0]                  addr;
  logic                           cnt_we;
  logic                           row_we;
  logic [ugnb_pkg::CNT_W-1:0]     cnt_wdata;
  logic [ugnb_pkg::CNT_W-1:0]     cnt_rdata;
  logic [ugnb_pkg::ROW_W-1:0]     row_wdata;
  logic [ugnb_pkg::ROW_W-1:0]     row_rdata;

  function automatic logic [AW-1:0] nbr_addr(input ugnb_pkg::cmd_t c,
                                             input logic [1:0] ax,
                                             input logic [1:0] ay,
                                             input logic [1:0] az);
    logic [5:0] px, py, pz;
    px = c.x + {4'd0, ax} - 6'd1;
    py = c.y + {4'd0, ay} - 6'd1;
    pz = c.z + {4'd0, az} - 6'd1;
    return {px[CB-1:0], py[CB-1:0], pz[CB-1:0]};
  endfunction

  ugnb_ram #(.WIDTH(ugnb_pkg::CNT_W), .DEPTH(DEPTH)) u_count (
    .clk(clk), .we(cnt_we), .addr(addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
  );

  ugnb_ram #(.WIDTH(ugnb_pkg::ROW_W), .DEPTH(DEPTH)) u_slots (
    .clk(clk), .we(row_we), .addr(addr), .wdata(row_wdata), .rdata(row_rdata)
  );

  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ugnb_pkg::S_INIT;
      walk      <= '0;
      res_valid <= 1'b0;
      dx        <= 2'd0;
      dy        <= 2'd0;
      dz        <= 2'd0;
      nbr       <= 5'd0;
    end else begin
      state <= state_next;
      if (state == ugnb_pkg::S_INIT || state == ugnb_pkg::S_CLEAR) begin
        walk <= walk + 1'b1;
      end
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (state == ugnb_pkg::S_Q_FIRST) begin
        dx  <= 2'd0;
        dy  <= 2'd0;
        dz  <= 2'd0;
        nbr <= 5'd0;
      end else if (state == ugnb_pkg::S_QUERY && out_free) begin
        dx  <= dx_next;
        dy  <= dy_next;
        dz  <= dz_next;
        nbr <= nbr + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    if (emit) begin
      res      <= res_next;
      res_last <= last_next;
    end
  end

  always_comb begin
    dz_next = dz + 2'd1;
    dy_next = dy;
    dx_next = dx;
    if (dz == 2'd2) begin
      dz_next = 2'd0;
      dy_next = dy + 2'd1;
      if (dy == 2'd2) begin
        dy_next = 2'd0;
        dx_next = dx + 2'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit       = 1'b0;
    cnt_we     = 1'b0;
    row_we     = 1'b0;
    cnt_wdata  = '0;
    row_wdata  = row_rdata;
    row_wdata[cnt_rdata[1:0]*ugnb_pkg::PID_W +: ugnb_pkg::PID_W] = cmd.pid;
    addr       = nbr_addr(cmd, 2'd1, 2'd1, 2'd1);
    last_next  = 1'b1;
    res_next.accepted   = 1'b1;
    res_next.overflowed = 1'b0;
    res_next.number     = 5'd0;
    for (int s = 0; s < ugnb_pkg::SLOTS_PER_CELL; s++) begin
      res_next.slots[s] = ugnb_pkg::EMPTY_SLOT;
    end

    case (state)
      ugnb_pkg::S_INIT: begin
        addr   = walk;
        cnt_we = 1'b1;
        if (&walk) begin
          state_next = ugnb_pkg::S_IDLE;
        end
      end
      ugnb_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            ugnb_pkg::OP_CLEAR:  state_next = ugnb_pkg::S_CLEAR;
            ugnb_pkg::OP_INSERT: state_next = ugnb_pkg::S_INS_RD;
            ugnb_pkg::OP_REJECT: state_next = ugnb_pkg::S_REJ;
            ugnb_pkg::OP_QUERY:  state_next = ugnb_pkg::S_Q_FIRST;
            default:             state_next = ugnb_pkg::S_IDLE;
          endcase
        end
      end
      ugnb_pkg::S_INS_RD: state_next = ugnb_pkg::S_INS_WR;
      ugnb_pkg::S_INS_WR: begin
        if (out_free) begin
          emit = 1'b1;
          if (cnt_rdata >= 3'(ugnb_pkg::SLOTS_PER_CELL)) begin
            res_next.accepted   = 1'b0;
            res_next.overflowed = 1'b1;
          end else begin
            cnt_we    = 1'b1;
            row_we    = 1'b1;
            cnt_wdata = cnt_rdata + 3'd1;
          end
          state_next = ugnb_pkg::S_IDLE;
        end
      end
      ugnb_pkg::S_REJ: begin
        if (out_free) begin
          emit = 1'b1;
          res_next.accepted = 1'b0;
          state_next = ugnb_pkg::S_IDLE;
        end
      end
      ugnb_pkg::S_CLEAR: begin
        addr   = walk;
        cnt_we = 1'b1;
        if (&walk) begin
          state_next = ugnb_pkg::S_CLR_DONE;
        end
      end
      ugnb_pkg::S_CLR_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          state_next = ugnb_pkg::S_IDLE;
        end
      end
      ugnb_pkg::S_Q_FIRST: begin
        addr       = nbr_addr(cmd, 2'd0, 2'd0, 2'd0);
        state_next = ugnb_pkg::S_QUERY;
      end
      ugnb_pkg::S_QUERY: begin
        // hold the read address while the output is stalled
        addr = out_free ? nbr_addr(cmd, dx_next, dy_next, dz_next)
                        : nbr_addr(cmd, dx, dy, dz);
        res_next.number = nbr;
        last_next       = nbr == 5'(ugnb_pkg::LAST_NBR);
        for (int s = 0; s < ugnb_pkg::SLOTS_PER_CELL; s++) begin
          if (3'(s) < cnt_rdata) begin
            res_next.slots[s] = {1'b0, row_rdata[s*ugnb_pkg::PID_W +: ugnb_pkg::PID_W]};
          end
        end
        if (out_free) begin
          emit = 1'b1;
          if (last_next) begin
            state_next = ugnb_pkg::S_IDLE;
          end
        end
      end
      default: state_next = ugnb_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_ovf_not_acc: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.overflowed |-> !res.accepted)
    else $error("overflow result marked accepted");

  a_last_nbr: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> res.number != 5'(ugnb_pkg::LAST_NBR) && res.accepted)
    else $error("query run ended at wrong position");

  a_query_hold: assert property (@(posedge clk) disable iff (rst)
    state == ugnb_pkg::S_QUERY && !out_free |=> $stable(nbr))
    else $error("query advanced while output stalled");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ugnb_pkg::S_IDLE)
    else $error("command taken while busy");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/uniform_grid_neighbor_binning.sv -----
// channel  | dir | handshake                     | content
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser kind, tdata coords + particle id
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata flags, number, slots; tlast
// cfg      | in  | cfg_valid / cfg_ready         | grid_length
//
// insert: count/slot read, then write; query: 27 results, one per cycle while the output
// is not stalled, from the count and slot memories, after a first-address setup state.
// clear walks every count entry, one per cycle: 2**(3*clog2(MAX_GRID_LENGTH)) entries
// (32768 at the default); the same pass runs after reset before any request is served.
// a two-entry command queue lets the input side keep taking requests while the
// output is stalled, until the queue fills; rst is synchronous, active high.
`default_nettype none
module uniform_grid_neighbor_binning #(
  parameter int MAX_GRID_LENGTH = ugnb_pkg::MAX_GRID_LENGTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [6:0] cell_x, [13:7] cell_y, [20:14] cell_z, [32:21] particle_id
  input  wire logic [39:0] s_axis_tdata,
  // [1:0] kind
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] accepted, [1] overflowed, [6:2] neighbor_number, [19:7] slot_zero,
  // [32:20] slot_one, [45:33] slot_two, [58:46] slot_three
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_data
);

  logic [5:0]     grid_length;
  logic           q_full;
  logic           q_push;
  ugnb_pkg::cmd_t push_cmd;
  logic           q_valid;
  logic           q_pop;
  ugnb_pkg::cmd_t pop_cmd;
  ugnb_pkg::res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_length <= 6'd32;
    end else if (cfg_valid) begin
      grid_length <= cfg_data;
    end
  end

  ugnb_front #(.MAX_GRID_LENGTH(MAX_GRID_LENGTH)) u_front (
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .kind(s_axis_tuser),
    .cell_x(s_axis_tdata[6:0]),
    .cell_y(s_axis_tdata[13:7]),
    .cell_z(s_axis_tdata[20:14]),
    .particle_id(s_axis_tdata[32:21]),
    .grid_length(grid_length),
    .q_full(q_full),
    .q_push(q_push),
    .q_cmd(push_cmd)
  );

  ugnb_cmd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_cmd(push_cmd),
    .full(q_full),
    .pop_valid(q_valid),
    .pop(q_pop),
    .pop_cmd(pop_cmd)
  );

  ugnb_back #(.MAX_GRID_LENGTH(MAX_GRID_LENGTH)) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_cmd(pop_cmd),
    .q_pop(q_pop),
    .res_valid(m_axis_tvalid),
    .res_ready(m_axis_tready),
    .res(res),
    .res_last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, res.slots[3], res.slots[2], res.slots[1], res.slots[0],
                         res.number, res.overflowed, res.accepted};

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import ugnb_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CELLS = MAX_GRID_LENGTH * MAX_GRID_LENGTH * MAX_GRID_LENGTH;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_data;

  uniform_grid_neighbor_binning dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  typedef struct {
    logic                    accepted;
    logic                    overflowed;
    logic [NUM_W-1:0]        number;
    logic [SLOT_W-1:0]       slots [SLOTS_PER_CELL];
    logic                    last;
  } cell_result_t;

  typedef struct {
    logic [1:0] kind;
    int         x, y, z, pid;
    bit         typed;
    bit         acc, ovf;
  } dir_row_t;

  cell_result_t expected_cells[$];
  logic [2:0]       cell_fill [CELLS];
  logic [PID_W-1:0] cell_pid  [CELLS][SLOTS_PER_CELL];
  logic [5:0]       grid_reg;
  int  mismatches;
  bit  calm;
  bit  sender_gaps;

  dir_row_t dir_rows [20] = '{
    '{KIND_CLEAR,   0,   0,   0,    0, 1, 1, 0},
    '{KIND_INSERT,  0,   0,   0,    0, 1, 1, 0},
    '{KIND_INSERT,  0,   0,   0, 4095, 1, 1, 0},
    '{KIND_INSERT,  0,   0,   0,    1, 1, 1, 0},
    '{KIND_INSERT,  0,   0,   0,    2, 1, 1, 0},
    '{KIND_INSERT,  0,   0,   0,    3, 1, 0, 1},
    '{KIND_INSERT, -1,   0,   0,    7, 1, 0, 0},
    '{KIND_INSERT,  0, -64,   0,    7, 1, 0, 0},
    '{KIND_INSERT,  0,   0,  32,    7, 1, 0, 0},
    '{KIND_INSERT, 63,  63,  63,    7, 1, 0, 0},
    '{KIND_INSERT, 31,  31,  31, 4095, 1, 1, 0},
    '{KIND_INSERT, 31,  30,  31,  100, 1, 1, 0},
    '{KIND_QUERY,   0,   0,   0,    0, 0, 0, 0},
    '{KIND_QUERY, -64, -64, -64,    0, 0, 0, 0},
    '{KIND_QUERY,  63,  63,  63,    0, 0, 0, 0},
    '{KIND_QUERY,  31,  31,  31,    0, 0, 0, 0},
    '{KIND_QUERY,  15,   7,  22,    0, 0, 0, 0},
    '{KIND_UNUSED,  5,   5,   5,    0, 0, 0, 0},
    '{KIND_INSERT,  1,   1,   1,    9, 1, 1, 0},
    '{KIND_QUERY,   1,   1,   1,    0, 0, 0, 0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int grid_in_use();
    int len;
    len = grid_reg;
    if (len < 3) len = 3;
    if (len > MAX_GRID_LENGTH) len = MAX_GRID_LENGTH;
    return len;
  endfunction

  function automatic int flat_cell(int x, int y, int z);
    return (x * MAX_GRID_LENGTH + y) * MAX_GRID_LENGTH + z;
  endfunction

  function automatic int clamp_inward(int v, int len);
    if (v < 1) return 1;
    if (v > len - 2) return len - 2;
    return v;
  endfunction

  task automatic push_status(logic acc, logic ovf);
    cell_result_t r;
    r.accepted = acc;
    r.overflowed = ovf;
    r.number = '0;
    for (int s = 0; s < SLOTS_PER_CELL; s++) r.slots[s] = EMPTY_SLOT;
    r.last = 1'b1;
    expected_cells.push_back(r);
  endtask

  // grid model: update state and queue the results one request causes
  task automatic bin_request(logic [1:0] kind, logic [6:0] rx, logic [6:0] ry,
                             logic [6:0] rz, logic [PID_W-1:0] pid);
    int len, x, y, z, c, k;
    cell_result_t r;
    len = grid_in_use();
    x = $signed(rx);
    y = $signed(ry);
    z = $signed(rz);
    case (kind)
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) cell_fill[i] = '0;
        push_status(1'b1, 1'b0);
      end
      KIND_INSERT: begin
        if (x < 0 || y < 0 || z < 0 || x >= len || y >= len || z >= len) begin
          push_status(1'b0, 1'b0);
        end else begin
          c = flat_cell(x, y, z);
          if (cell_fill[c] >= SLOTS_PER_CELL) begin
            push_status(1'b0, 1'b1);
          end else begin
            cell_pid[c][cell_fill[c]] = pid;
            cell_fill[c] = cell_fill[c] + 1;
            push_status(1'b1, 1'b0);
          end
        end
      end
      KIND_QUERY: begin
        x = clamp_inward(x, len);
        y = clamp_inward(y, len);
        z = clamp_inward(z, len);
        k = 0;
        for (int dx = -1; dx <= 1; dx++)
          for (int dy = -1; dy <= 1; dy++)
            for (int dz = -1; dz <= 1; dz++) begin
              c = flat_cell(x + dx, y + dy, z + dz);
              r.accepted = 1'b1;
              r.overflowed = 1'b0;
              r.number = k[NUM_W-1:0];
              for (int s = 0; s < SLOTS_PER_CELL; s++)
                r.slots[s] = (s < cell_fill[c]) ? {1'b0, cell_pid[c][s]} : EMPTY_SLOT;
              r.last = (k == LAST_NBR);
              expected_cells.push_back(r);
              k++;
            end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(logic [1:0] kind, int x, int y, int z, int pid);
    int gap;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, pid[11:0], z[6:0], y[6:0], x[6:0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bin_request(kind, x[6:0], y[6:0], z[6:0], pid[11:0]);
  endtask

  task automatic write_grid_length(logic [5:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    // let the back end settle before the register changes
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    grid_reg = value;
  endtask

  // output side: random stall bursts
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm && $urandom_range(0, 1) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        cell_result_t e;
        bit bad;
        e = expected_cells.pop_front();
        bad = (m_axis_tdata[0] !== e.accepted) || (m_axis_tdata[1] !== e.overflowed) ||
              (m_axis_tdata[6:2] !== e.number) || (m_axis_tdata[19:7] !== e.slots[0]) ||
              (m_axis_tdata[32:20] !== e.slots[1]) || (m_axis_tdata[45:33] !== e.slots[2]) ||
              (m_axis_tdata[58:46] !== e.slots[3]) || (m_axis_tlast !== e.last);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp acc %b ovf %b num %0d slots %h %h %h %h last %b | got %h last %b",
                     e.accepted, e.overflowed, e.number, e.slots[0], e.slots[1], e.slots[2],
                     e.slots[3], e.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    logic [5:0] settings [7];
    int len, pick, box, sent;
    settings = '{6'd3, 6'd0, 6'd63, 6'd2, 6'd17, 6'd33, 6'd5};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_CLEAR;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    calm = 0;
    sender_gaps = 1;
    grid_reg = 6'd32;
    for (int i = 0; i < CELLS; i++) cell_fill[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].kind, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                   dir_rows[i].pid);
      if (dir_rows[i].typed) begin
        expected_cells[$].accepted = dir_rows[i].acc;
        expected_cells[$].overflowed = dir_rows[i].ovf;
      end
    end

    foreach (settings[p]) begin
      write_grid_length(settings[p]);
      len = grid_in_use();
      // some phases keep the old contents to cover a length change without a clear
      if (p % 2 == 0) send_request(KIND_CLEAR, 0, 0, 0, 0);
      sent = 0;
      while (sent < 46) begin
        if (p == 6 && sent > 20) begin
          calm = 1;
          sender_gaps = 0;
        end
        pick = $urandom_range(0, 99);
        box = ($urandom_range(0, 1) == 1) ? ((len < 4) ? len - 1 : 3) : len - 1;
        if (pick < 55) begin
          send_request(KIND_INSERT, $urandom_range(0, box), $urandom_range(0, box),
                       $urandom_range(0, box), $urandom_range(0, 4095));
        end else if (pick < 67) begin
          send_request(KIND_INSERT, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 92) begin
          if ($urandom_range(0, 3) == 0)
            send_request(KIND_QUERY, $urandom, $urandom, $urandom, $urandom);
          else
            send_request(KIND_QUERY, $urandom_range(0, box), $urandom_range(0, box),
                         $urandom_range(0, box), $urandom);
        end else begin
          send_request(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
          sent--;
        end
        sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
